[design/khci_pkg.sv]
// Package for the k-tuple hash-chain index: default sizes, head-table word
// layout, register map codes and the result record.
// Used by ktuple_hash_chain_index; depends on nothing else.
package khci_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_KTUP_DEF    = 6;
   localparam int TABLE_DEPTH_DEF = 65536;
   localparam int MAX_LEN_DEF     = 65535;

   // Head-table word: sequence epoch tag over a 16-bit start position.
   localparam int EPOCH_W = 8;
   localparam int START_W = 16;
   localparam int MEM_W   = EPOCH_W + START_W;

   // Register reset values.
   localparam logic [2:0] WINDOW_LEN_RST    = 3'd2;
   localparam logic [4:0] ALPHABET_SIZE_RST = 5'd20;

   // Register index, taken from the word address.
   typedef enum logic [0:0] {
      REG_WINDOW_LEN    = 1'b0,
      REG_ALPHABET_SIZE = 1'b1
   } csr_reg_type;

   // Head-table maintenance state.
   typedef enum logic [0:0] {
      ST_RUN   = 1'b0,
      ST_CLEAR = 1'b1
   } tbl_state_type;

   // One result as it waits in the output queue.
   typedef struct packed {
      logic [15:0] window_start;
      logic [15:0] prev_start;
      logic        window_ok;
      logic [15:0] tuple_code;
   } rsp_type;

endpackage

[design/ktuple_hash_chain_index.sv]
// Top level of the k-tuple hash-chain index: window shifter, Horner code
// pipeline, head-table read-modify-write and output queue.
// Depends on khci_pkg.
//
// Path: the front stage, the Horner stages, the update stage, then the output queue.
// Throughput: one request per cycle while req_stall is low; one head-table read and one write per
// cycle, with forwarding of the previous write into the next read.
// Reset: synchronous; after reset, and whenever the 8-bit sequence epoch
// wraps, a clearing pass over all TABLE_DEPTH entries runs with requests stalled.
module ktuple_hash_chain_index #(
   parameter int MAX_KTUP    = khci_pkg::MAX_KTUP_DEF,
   parameter int TABLE_DEPTH = khci_pkg::TABLE_DEPTH_DEF,
   parameter int MAX_LEN     = khci_pkg::MAX_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [4:0]  req_residue,
   input  logic        req_is_gap,
   input  logic        req_seq_start,
   // Result channel.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_window_start,
   output logic [15:0] rsp_prev_start,
   output logic        rsp_window_ok,
   output logic [15:0] rsp_tuple_code,
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import khci_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int KW     = $clog2(MAX_KTUP + 1);
   localparam int POS_A  = $clog2(MAX_LEN + 1);
   localparam int POS_W  = (POS_A > 16) ? POS_A : 16;
   localparam int CODE_A = 5 * MAX_KTUP;
   localparam int CODE_B = (IDX_W + 1 > 16) ? IDX_W + 1 : 16;
   localparam int CODE_W = (CODE_A > CODE_B) ? CODE_A : CODE_B;
   localparam int FW     = $clog2(MAX_KTUP + 4);
   localparam int FIFO_DEPTH = 1 << FW;
   localparam int CNT_W  = FW + 1;

   typedef struct packed {
      logic                      full;
      logic                      gapped;
      logic [POS_W-1:0]          start;
      logic [KW-1:0]             k;
      logic [5:0]                base;
      logic [EPOCH_W-1:0]        epoch;
      logic [CODE_W-1:0]         acc;
      logic [MAX_KTUP-1:0][4:0]  syms;
   } stage_type;

   typedef struct packed {
      stage_type          st;
      logic               ok;
      logic [IDX_W-1:0]   addr;
   } rd_type;

   // Registers.
   logic [2:0]               window_len_ff;
   logic [4:0]               alphabet_size_ff;
   logic [MAX_KTUP-1:0][4:0] syms_ff;
   logic [MAX_KTUP-1:0]      gaps_ff;
   logic [POS_W-1:0]         pos_ff;
   logic [EPOCH_W-1:0]       epoch_ff;
   tbl_state_type            state_ff;
   logic [IDX_W-1:0]         sweep_addr_ff;
   stage_type                pipe_ff [MAX_KTUP+1];
   logic [MAX_KTUP:0]        pipe_vld_ff;
   rd_type                   rd_ff;
   logic                     rd_vld_ff;
   logic [MEM_W-1:0]         mem_rd_ff;
   logic                     fwd_vld_ff;
   logic [IDX_W-1:0]         fwd_addr_ff;
   logic [MEM_W-1:0]         fwd_word_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [FW:0]              wr_ptr_ff;
   logic [FW:0]              rd_ptr_ff;

   // Next values.
   logic [MAX_KTUP-1:0][4:0] syms_in;
   logic [MAX_KTUP-1:0]      gaps_in;
   logic [POS_W-1:0]         pos_in;
   logic [EPOCH_W-1:0]       epoch_in;
   tbl_state_type            state_in;
   stage_type                front_in;
   stage_type                horner_in [MAX_KTUP];
   rd_type                   rd_in;
   logic [CNT_W-1:0]         count_in;

   // Memories.
   logic [MEM_W-1:0]         head_mem [TABLE_DEPTH];
   rsp_type                  fifo_mem [FIFO_DEPTH];

   // Combinational signals.
   logic                     accept;
   logic                     pop;
   logic                     clearing;
   logic                     wrap_hold;
   logic                     wrap_start;
   logic                     sweep_last;
   logic                     pipe_busy;
   logic                     csr_wr;
   csr_reg_type              csr_sel;
   logic [MAX_KTUP-1:0][4:0] syms_cl;
   logic [MAX_KTUP-1:0]      gaps_cl;
   logic [POS_W-1:0]         pos_cl;
   logic                     take;
   logic [3:0]               wl_ext;
   logic [KW-1:0]            k_eff;
   logic [CODE_W+5:0]        prod [MAX_KTUP];
   logic [CODE_W-1:0]        code_end;
   logic [MEM_W-1:0]         word_cur;
   logic                     tag_hit;
   logic                     mem_we;
   logic [IDX_W-1:0]         mem_waddr;
   logic [MEM_W-1:0]         mem_wdata;
   rsp_type                  rsp_push;

   // Register port: writes complete in the access phase, reads are direct.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_sel    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      unique case (csr_sel)
         REG_WINDOW_LEN:    csr_prdata = {29'd0, window_len_ff};
         REG_ALPHABET_SIZE: csr_prdata = {27'd0, alphabet_size_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff    <= WINDOW_LEN_RST;
         alphabet_size_ff <= ALPHABET_SIZE_RST;
      end else if (csr_wr) begin
         unique case (csr_sel)
            REG_WINDOW_LEN:    window_len_ff    <= csr_pwdata[2:0];
            REG_ALPHABET_SIZE: alphabet_size_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   // Handshakes. Total items in flight and queued never pass the queue depth,
   // so the pipeline itself never has to stop.
   assign pipe_busy = (|pipe_vld_ff) || rd_vld_ff;
   assign wrap_hold = req_valid && req_seq_start && (epoch_ff == {EPOCH_W{1'b1}});
   assign wrap_start = wrap_hold && !pipe_busy && (state_ff == ST_RUN);
   assign req_stall = clearing || wrap_hold || (count_ff == CNT_W'(FIFO_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (wr_ptr_ff != rd_ptr_ff);
   assign pop       = rsp_valid && !rsp_stall;
   assign sweep_last = (sweep_addr_ff == IDX_W'(TABLE_DEPTH - 1));

   // Table maintenance: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:   if (wrap_start) state_in = ST_CLEAR;
         ST_CLEAR: if (sweep_last) state_in = ST_RUN;
         default:  state_in = ST_RUN;
      endcase
   end

   // Table maintenance: outputs.
   always_comb begin
      unique case (state_ff)
         ST_RUN:   clearing = 1'b0;
         ST_CLEAR: clearing = 1'b1;
         default:  clearing = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         sweep_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wrap_start) begin
            sweep_addr_ff <= '0;
         end else if (clearing) begin
            sweep_addr_ff <= sweep_addr_ff + 1'b1;
         end
      end
   end

   // Window shifter: a new sequence clears the window first, then the symbol
   // is shifted in unless the sequence has reached its length limit.
   always_comb begin
      syms_cl = req_seq_start ? '0 : syms_ff;
      gaps_cl = req_seq_start ? '0 : gaps_ff;
      pos_cl  = req_seq_start ? '0 : pos_ff;
      take    = (pos_cl < POS_W'(MAX_LEN));

      syms_in    = syms_cl;
      gaps_in    = gaps_cl;
      pos_in     = pos_cl;
      syms_in[0] = req_is_gap ? 5'd0 : req_residue;
      gaps_in[0] = req_is_gap;
      for (int i = 1; i < MAX_KTUP; i++) begin
         syms_in[i] = syms_cl[i-1];
         gaps_in[i] = gaps_cl[i-1];
      end
      pos_in = pos_cl + 1'b1;
      if (!take) begin
         syms_in = syms_cl;
         gaps_in = gaps_cl;
         pos_in  = pos_cl;
      end
   end

   // Effective window length, clamped to one through MAX_KTUP.
   always_comb begin
      wl_ext = {1'b0, window_len_ff};
      if (wl_ext == 4'd0) begin
         k_eff = KW'(1);
      end else if (wl_ext > 4'(MAX_KTUP)) begin
         k_eff = KW'(MAX_KTUP);
      end else begin
         k_eff = KW'(wl_ext);
      end
   end

   // First pipeline stage: window snapshot, start position and gap check.
   always_comb begin
      front_in.full   = take && (pos_in >= POS_W'(k_eff));
      front_in.start  = pos_in - POS_W'(k_eff) + 1'b1;
      front_in.k      = k_eff;
      front_in.base   = {1'b0, alphabet_size_ff} + 6'd1;
      front_in.epoch  = req_seq_start ? epoch_ff + 1'b1 : epoch_ff;
      front_in.acc    = '0;
      front_in.syms   = syms_in;
      front_in.gapped = 1'b0;
      for (int i = 0; i < MAX_KTUP; i++) begin
         if ((i < int'(k_eff)) && gaps_in[i]) front_in.gapped = 1'b1;
      end
   end

   // Epoch advances on every new sequence and restarts at a clearing pass.
   always_comb begin
      epoch_in = epoch_ff;
      if (wrap_start) begin
         epoch_in = '0;
      end else if (accept && req_seq_start) begin
         epoch_in = epoch_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         syms_ff  <= '0;
         gaps_ff  <= '0;
         pos_ff   <= '0;
         epoch_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
         if (accept) begin
            syms_ff <= syms_in;
            gaps_ff <= gaps_in;
            pos_ff  <= pos_in;
         end
      end
   end

   // Horner stages, newest symbol first: one multiply-add per place.
   always_comb begin
      for (int j = 0; j < MAX_KTUP; j++) begin
         horner_in[j] = pipe_ff[j];
         prod[j] = pipe_ff[j].acc * pipe_ff[j].base;
         if (j < int'(pipe_ff[j].k)) begin
            horner_in[j].acc = CODE_W'(prod[j]) + CODE_W'(pipe_ff[j].syms[j]);
         end
      end
   end

   // Range check and head-table address for the finished code.
   always_comb begin
      code_end   = pipe_ff[MAX_KTUP].acc;
      rd_in.st   = pipe_ff[MAX_KTUP];
      rd_in.addr = code_end[IDX_W-1:0];
      rd_in.ok   = pipe_ff[MAX_KTUP].full && !pipe_ff[MAX_KTUP].gapped &&
                   (code_end < CODE_W'(TABLE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         pipe_vld_ff <= {pipe_vld_ff[MAX_KTUP-1:0], accept};
         rd_vld_ff   <= pipe_vld_ff[MAX_KTUP];
      end
   end

   always_ff @(posedge clock) begin
      pipe_ff[0] <= front_in;
      for (int j = 0; j < MAX_KTUP; j++) begin
         pipe_ff[j+1] <= horner_in[j];
      end
      rd_ff <= rd_in;
   end

   // Update stage: the last cycle's write is forwarded over the stale read,
   // and an entry from an older sequence reads as no earlier start.
   always_comb begin
      word_cur = (fwd_vld_ff && (fwd_addr_ff == rd_ff.addr)) ? fwd_word_ff : mem_rd_ff;
      tag_hit  = (word_cur[MEM_W-1 -: EPOCH_W] == rd_ff.st.epoch);

      rsp_push.window_start = rd_ff.st.full ? rd_ff.st.start[15:0] : 16'd0;
      rsp_push.prev_start   = (rd_ff.ok && tag_hit) ? word_cur[START_W-1:0] : 16'd0;
      rsp_push.window_ok    = rd_ff.ok;
      rsp_push.tuple_code   = (rd_ff.st.full && !rd_ff.st.gapped) ?
                              rd_ff.st.acc[15:0] : 16'd0;
   end

   // Head-table write port: the clearing pass, else the update stage.
   always_comb begin
      if (clearing) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_addr_ff;
         mem_wdata = {epoch_ff, {START_W{1'b0}}};
      end else begin
         mem_we    = rd_vld_ff && rd_ff.ok;
         mem_waddr = rd_ff.addr;
         mem_wdata = {rd_ff.st.epoch, rd_ff.st.start[START_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) head_mem[mem_waddr] <= mem_wdata;
      mem_rd_ff <= head_mem[rd_in.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else begin
         fwd_vld_ff <= rd_vld_ff && rd_ff.ok;
      end
      fwd_addr_ff <= rd_ff.addr;
      fwd_word_ff <= {rd_ff.st.epoch, rd_ff.st.start[START_W-1:0]};
   end

   // Output queue and the count of requests not yet delivered.
   always_comb begin
      count_in = count_ff + CNT_W'(accept) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (rd_vld_ff) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)       rd_ptr_ff <= rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) fifo_mem[wr_ptr_ff[FW-1:0]] <= rsp_push;
   end

   assign rsp_window_start = fifo_mem[rd_ptr_ff[FW-1:0]].window_start;
   assign rsp_prev_start   = fifo_mem[rd_ptr_ff[FW-1:0]].prev_start;
   assign rsp_window_ok    = fifo_mem[rd_ptr_ff[FW-1:0]].window_ok;
   assign rsp_tuple_code   = fifo_mem[rd_ptr_ff[FW-1:0]].tuple_code;

endmodule
